// ===== hw/rtl/spq_pkg.sv =====
// Shared types and constants for the sorted priority queue.
package spq_pkg;

    localparam int CAPACITY = 16;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int VAL_W    = 32;
    localparam int PRI_W    = 16;

    typedef logic signed [VAL_W-1:0] t_value;
    typedef logic        [PRI_W-1:0] t_prio;
    typedef logic        [CNT_W-1:0] t_count;
    typedef logic        [1:0]       t_status;

    localparam logic OP_ENQ = 1'b0;
    localparam logic OP_DEQ = 1'b1;

    localparam t_status ST_DONE  = 2'd0;
    localparam t_status ST_EMPTY = 2'd1;
    localparam t_status ST_FULL  = 2'd2;

    typedef struct packed {
        logic enq;
        logic deq;
    } t_cell_cmd;

endpackage

// ===== hw/rtl/spq_cell.sv =====
// One storage cell of the sorted chain, holding a single value and priority.
module spq_cell (
    input  logic              i_clk,
    input  spq_pkg::t_cell_cmd i_cmd,
    input  logic              i_occupied,
    input  spq_pkg::t_value   i_new_value,
    input  spq_pkg::t_prio    i_new_prio,
    input  logic              i_left_le,
    input  spq_pkg::t_value   i_left_value,
    input  spq_pkg::t_prio    i_left_prio,
    input  spq_pkg::t_value   i_right_value,
    input  spq_pkg::t_prio    i_right_prio,
    output logic              o_le,
    output spq_pkg::t_value   o_value,
    output spq_pkg::t_prio    o_prio
);
    import spq_pkg::*;

    t_value r_value;
    t_prio  r_prio;
    t_value n_value;
    t_prio  n_prio;

    assign o_le    = i_occupied && (r_prio <= i_new_prio);
    assign o_value = r_value;
    assign o_prio  = r_prio;

    always_comb begin
        n_value = r_value;
        n_prio  = r_prio;
        if (i_cmd.enq && !o_le) begin
            if (i_left_le) begin
                n_value = i_new_value;
                n_prio  = i_new_prio;
            end else begin
                n_value = i_left_value;
                n_prio  = i_left_prio;
            end
        end else if (i_cmd.deq) begin
            n_value = i_right_value;
            n_prio  = i_right_prio;
        end
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
        r_prio  <= n_prio;
    end

endmodule

// ===== hw/rtl/sorted_priority_queue_top.sv =====
// Top level of the sorted priority queue built as a chain of storage cells.
// The result of an item is registered when the item is accepted.
// Throughput: one item per cycle while o_stall is low; all cells compare against the new priority
// in parallel and shift by one place in the same cycle.
// Reset clears the entry count and the output valid; cell contents are kept
// and are only read below the count.
module sorted_priority_queue_top (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_stall,
    input  logic [0:0]          i_opcode,
    input  spq_pkg::t_value     i_item_value,
    input  spq_pkg::t_prio      i_item_priority,
    output logic                o_valid,
    input  logic                i_stall,
    output spq_pkg::t_value     o_out_value,
    output spq_pkg::t_status    o_status,
    output spq_pkg::t_count     o_entry_count,
    output logic                o_queue_empty
);
    import spq_pkg::*;

    t_count    r_count;
    t_count    n_count;
    logic      r_out_valid;
    t_value    r_out_value;
    t_status   r_status;
    t_value    n_out_value;
    t_status   n_status;
    logic      accept;
    logic      is_full;
    logic      is_empty;
    t_cell_cmd cmd;

    t_value    cell_value [CAPACITY];
    t_prio     cell_prio  [CAPACITY];
    logic      cell_le    [CAPACITY];

    assign o_stall  = r_out_valid && i_stall;
    assign accept   = i_valid && !o_stall;
    assign is_full  = (r_count == CNT_W'(CAPACITY));
    assign is_empty = (r_count == '0);

    always_comb begin
        cmd.enq     = 1'b0;
        cmd.deq     = 1'b0;
        n_count     = r_count;
        n_out_value = '0;
        n_status    = ST_DONE;
        if (i_opcode[0] == OP_ENQ) begin
            if (is_full) begin
                n_status = ST_FULL;
            end else begin
                cmd.enq = accept;
                n_count = r_count + 1'b1;
            end
        end else begin
            if (is_empty) begin
                n_status = ST_EMPTY;
            end else begin
                cmd.deq     = accept;
                n_count     = r_count - 1'b1;
                n_out_value = cell_value[0];
            end
        end
    end

    for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
        logic   left_le;
        t_value left_value;
        t_prio  left_prio;
        t_value right_value;
        t_prio  right_prio;

        if (i == 0) begin : g_first
            assign left_le    = 1'b0;
            assign left_value = i_item_value;
            assign left_prio  = i_item_priority;
        end else begin : g_mid
            assign left_le    = cell_le[i-1];
            assign left_value = cell_value[i-1];
            assign left_prio  = cell_prio[i-1];
        end

        if (i == CAPACITY - 1) begin : g_last
            assign right_value = cell_value[i];
            assign right_prio  = cell_prio[i];
        end else begin : g_inner
            assign right_value = cell_value[i+1];
            assign right_prio  = cell_prio[i+1];
        end

        spq_cell u_cell (
            .i_clk         (i_clk),
            .i_cmd         (cmd),
            .i_occupied    (CNT_W'(i) < r_count),
            .i_new_value   (i_item_value),
            .i_new_prio    (i_item_priority),
            .i_left_le     (left_le),
            .i_left_value  (left_value),
            .i_left_prio   (left_prio),
            .i_right_value (right_value),
            .i_right_prio  (right_prio),
            .o_le          (cell_le[i]),
            .o_value       (cell_value[i]),
            .o_prio        (cell_prio[i])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_out_value <= n_out_value;
            r_status    <= n_status;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_out_value   = r_out_value;
    assign o_status      = r_status;
    assign o_entry_count = r_count;
    assign o_queue_empty = (r_count == '0);

endmodule

// ===== hw/rtl/spq_checker.sv =====
// Port-level assertions for the sorted priority queue and their binding.
module spq_checker (
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             o_valid,
    input logic             i_stall,
    input spq_pkg::t_value  o_out_value,
    input spq_pkg::t_status o_status,
    input spq_pkg::t_count  o_entry_count,
    input logic             o_queue_empty
);
    import spq_pkg::*;

    a_empty_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_queue_empty == (o_entry_count == '0)))
        else $error("Empty flag disagrees with entry count.");

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_entry_count <= CNT_W'(CAPACITY)))
        else $error("Entry count exceeds capacity.");

    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status != ST_DONE) |-> (o_out_value == '0))
        else $error("Rejected item returned a nonzero value.");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_status == ST_DONE || o_status == ST_EMPTY || o_status == ST_FULL))
        else $error("Undefined status code.");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_out_value) && $stable(o_status)))
        else $error("Stalled result changed.");

endmodule

bind sorted_priority_queue_top spq_checker u_spq_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .o_valid       (o_valid),
    .i_stall       (i_stall),
    .o_out_value   (o_out_value),
    .o_status      (o_status),
    .o_entry_count (o_entry_count),
    .o_queue_empty (o_queue_empty)
);

// ===== tb/sorted_priority_queue_top_test.sv =====
// Self-checking testbench for the sorted priority queue top level.
`timescale 1ns / 1ps

module sorted_priority_queue_top_test;

    import spq_pkg::*;

    localparam int STALL_LIMIT = 1000;

    typedef struct packed {
        t_value value;
        t_prio  prio;
    } t_entry;

    typedef struct {
        t_value  value;
        t_status status;
        t_count  count;
        logic    empty;
    } t_result;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_valid = 1'b0;
    logic       o_stall;
    logic [0:0] i_opcode = OP_ENQ;
    t_value     i_item_value = '0;
    t_prio      i_item_priority = '0;
    logic       o_valid;
    logic       i_stall = 1'b0;
    t_value     o_out_value;
    t_status    o_status;
    t_count     o_entry_count;
    logic       o_queue_empty;

    t_entry  queue_contents[$];
    t_result pending_results[$];
    t_result oldest_result;
    int      error_count = 0;
    int      quiet_cycles = 0;
    bit      allow_idle = 1'b1;

    sorted_priority_queue_top dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_opcode        (i_opcode),
        .i_item_value    (i_item_value),
        .i_item_priority (i_item_priority),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_out_value     (o_out_value),
        .o_status        (o_status),
        .o_entry_count   (o_entry_count),
        .o_queue_empty   (o_queue_empty)
    );

    always #1 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        i_stall <= allow_idle && i_rst_n && ($urandom_range(99) < 8);
    end

    // An enqueue goes behind every stored entry of equal or lower priority number.
    function automatic t_result apply_operation(logic op, t_value value, t_prio prio);
        t_result res;
        t_entry  ent;
        int      pos;
        res.value  = '0;
        res.status = ST_DONE;
        if (op == OP_ENQ) begin
            if (queue_contents.size() >= CAPACITY) begin
                res.status = ST_FULL;
            end else begin
                pos = 0;
                while (pos < queue_contents.size() && queue_contents[pos].prio <= prio)
                    pos++;
                ent.value = value;
                ent.prio  = prio;
                queue_contents.insert(pos, ent);
            end
        end else if (queue_contents.size() == 0) begin
            res.status = ST_EMPTY;
        end else begin
            ent = queue_contents.pop_front();
            res.value = ent.value;
        end
        res.count = t_count'(queue_contents.size());
        res.empty = (queue_contents.size() == 0);
        return res;
    endfunction

    function automatic t_prio pick_priority(int mode);
        case (mode)
            0: return t_prio'($urandom_range(3));
            1: return t_prio'($urandom_range(16'hFFFF));
            default: begin
                case ($urandom_range(3))
                    0: return 16'h0000;
                    1: return 16'h7FFF;
                    2: return 16'h8000;
                    default: return 16'hFFFF;
                endcase
            end
        endcase
    endfunction

    task automatic send_item(input logic op, input t_value value, input t_prio prio);
        while (allow_idle && $urandom_range(99) < 8) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid         <= 1'b1;
        i_opcode        <= op;
        i_item_value    <= value;
        i_item_priority <= prio;
        do @(posedge i_clk); while (o_stall);
        pending_results.push_back(apply_operation(op, value, prio));
    endtask

    task automatic wait_for_results();
        i_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
    endtask

    task automatic run_random_phases(input int n_items);
        int sent;
        int enq_pct;
        int prio_mode;
        int phase_len;
        sent = 0;
        while (sent < n_items) begin
            phase_len = $urandom_range(40, 10);
            prio_mode = $urandom_range(2);
            case ($urandom_range(2))
                0: enq_pct = 80;
                1: enq_pct = 25;
                default: enq_pct = 50;
            endcase
            for (int k = 0; k < phase_len && sent < n_items; k++) begin
                send_item(($urandom_range(99) < enq_pct) ? OP_ENQ : OP_DEQ,
                          t_value'($urandom), pick_priority(prio_mode));
                sent++;
            end
        end
    endtask

    task automatic test_dequeue_empty();
        send_item(OP_DEQ, 32'hFFFF_FFFF, 16'hFFFF);
    endtask

    // Fills the queue with extreme values and tied priorities, overflows it, then dequeues four entries.
    task automatic test_fill_to_capacity();
        t_prio  prio;
        t_value value;
        for (int i = 0; i < CAPACITY; i++) begin
            case (i % 4)
                0: prio = 16'hFFFF;
                1: prio = 16'h0000;
                2: prio = 16'h7FFF;
                default: prio = 16'h0000;
            endcase
            value = i[0] ? t_value'(32'h7FFF_FFFF - i) : t_value'(32'h8000_0000 + i);
            send_item(OP_ENQ, value, prio);
        end
        send_item(OP_ENQ, 32'hFFFF_FFFF, 16'h0000);
        repeat (4) send_item(OP_DEQ, 32'h0000_0000, 16'h0000);
    endtask

    task automatic test_random_traffic();
        allow_idle = 1'b1;
        run_random_phases(500);
    endtask

    task automatic test_back_to_back();
        allow_idle = 1'b0;
        run_random_phases(150);
        allow_idle = 1'b1;
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected item: value %0d status %0d count %0d empty %0b",
                         $time, o_out_value, o_status, o_entry_count, o_queue_empty);
                error_count++;
            end else begin
                oldest_result = pending_results.pop_front();
                if (o_out_value !== oldest_result.value) begin
                    $display("%0t: out_value expected %0d, got %0d",
                             $time, oldest_result.value, o_out_value);
                    error_count++;
                end
                if (o_status !== oldest_result.status) begin
                    $display("%0t: status expected %0d, got %0d",
                             $time, oldest_result.status, o_status);
                    error_count++;
                end
                if (o_entry_count !== oldest_result.count) begin
                    $display("%0t: entry_count expected %0d, got %0d",
                             $time, oldest_result.count, o_entry_count);
                    error_count++;
                end
                if (o_queue_empty !== oldest_result.empty) begin
                    $display("%0t: queue_empty expected %0b, got %0b",
                             $time, oldest_result.empty, o_queue_empty);
                    error_count++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
            $display("Test completed with failures");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_dequeue_empty();
        test_fill_to_capacity();
        wait_for_results();
        test_random_traffic();
        wait_for_results();
        test_back_to_back();
        wait_for_results();
        repeat (8) @(posedge i_clk);
        if (error_count == 0 && pending_results.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
